>>> hw/rtl/ppm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants for the phrase position matcher
// Field widths, window depth, register indexes and the occurrence record.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int MaxParts  = 8;
  localparam int HistDepth = MaxParts - 1;
  localparam int OffW      = $clog2(MaxParts);
  localparam int CntW      = 4;
  localparam int DocW      = 32;
  localparam int SecW      = 8;
  localparam int PosW      = 16;
  localparam int PartW     = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 8;

  localparam logic [CfgIdxW-1:0] RegPartsCount = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegWordNumber = CfgIdxW'(1);

  localparam logic [CntW-1:0] PartsCountReset = CntW'(2);

  typedef struct packed {
    logic [DocW-1:0]  doc_id;
    logic [SecW-1:0]  section;
    logic [PosW-1:0]  position;
    logic [PartW-1:0] part_number;
  } item_t;

  typedef struct packed {
    logic [DocW-1:0]  doc_id;
    logic [SecW-1:0]  section;
    logic [PosW-1:0]  position;
    logic [PartW-1:0] word_number;
  } hit_t;

endpackage

>>> hw/rtl/ppm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_cell: one window entry of the phrase matcher
// Holds one earlier occurrence, compares it against the current beat at a
// fixed distance back, and passes its entry to the next cell on each beat.
// ----------------------------------------------------------------------------
module ppm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [ppm_pkg::OffW-1:0]  offset,
  input  ppm_pkg::item_t            cur,
  input  logic                      cur_list_start,
  input  ppm_pkg::item_t            prev_entry,
  input  logic                      prev_valid,
  output ppm_pkg::item_t            entry,
  output logic                      valid,
  output logic                      match
);

  logic [ppm_pkg::PosW:0]  pos_sum;
  logic [ppm_pkg::PartW:0] part_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= prev_entry;
    end
  end

  // entry.pos + offset == cur.pos with no wrap means cur.pos - offset >= 0
  assign pos_sum  = {1'b0, entry.position} + (ppm_pkg::PosW + 1)'(offset);
  assign part_sum = {1'b0, entry.part_number} + (ppm_pkg::PartW + 1)'(offset);

  assign match = valid && !cur_list_start
              && (entry.doc_id == cur.doc_id)
              && (entry.section == cur.section)
              && (pos_sum == {1'b0, cur.position})
              && (part_sum == {1'b0, cur.part_number});

endmodule

>>> hw/rtl/ppm_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_out_buf: two-entry result buffer
// Output register plus skid slot, so input beats keep flowing while a hit
// waits on the output.
// ----------------------------------------------------------------------------
module ppm_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ppm_pkg::hit_t push_data,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output ppm_pkg::hit_t head
);

  ppm_pkg::hit_t spare;
  logic [1:0]    count;
  logic [1:0]    count_next;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      head <= push_data;
    end else if (pop && count == 2'd2) begin
      head <= spare;
    end
    if (push && count == 2'd1 && !pop) begin
      spare <= push_data;
    end
  end

endmodule

>>> hw/rtl/phrase_position_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phrase_position_matcher: positional phrase match over sorted occurrences
//
//   channel  direction  beat carries
//   in       input      list_start, doc_id, section, position, part_number
//   out      output     hit_doc_id, hit_section, hit_position, hit_word_number
//   cfg      input      cfg_index, cfg_data (always ready)
//
// One input beat per cycle while in_ready is high; each hit is registered in the
// result buffer before it appears on out. All window compares run in parallel in
// the cell row in the accept cycle. in_ready drops only when both result slots are full.
// Reset clears the window valid bits, the result buffer and the word number register, and sets parts_count to 2.
// ----------------------------------------------------------------------------
module phrase_position_matcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          list_start,
  input  logic [ppm_pkg::DocW-1:0]      doc_id,
  input  logic [ppm_pkg::SecW-1:0]      section,
  input  logic [ppm_pkg::PosW-1:0]      position,
  input  logic [ppm_pkg::PartW-1:0]     part_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ppm_pkg::DocW-1:0]      hit_doc_id,
  output logic [ppm_pkg::SecW-1:0]      hit_section,
  output logic [ppm_pkg::PosW-1:0]      hit_position,
  output logic [ppm_pkg::PartW-1:0]     hit_word_number,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ppm_pkg::CfgDataW-1:0]  cfg_data
);

  logic [ppm_pkg::CntW-1:0]   parts_count;
  logic [ppm_pkg::PartW-1:0]  phrase_word_number;
  logic [ppm_pkg::CntW-1:0]   eff_n;
  logic                       accept;
  logic                       passthrough;
  logic                       hit;
  logic                       push;
  ppm_pkg::item_t             cur;
  ppm_pkg::hit_t              hit_data;
  ppm_pkg::hit_t              head;

  ppm_pkg::item_t             entries [ppm_pkg::HistDepth];
  logic [ppm_pkg::HistDepth-1:0] valids;
  logic [ppm_pkg::HistDepth-1:0] cell_hits;
  logic [ppm_pkg::HistDepth-1:0] needed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      parts_count        <= ppm_pkg::PartsCountReset;
      phrase_word_number <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ppm_pkg::RegPartsCount) begin
        parts_count <= cfg_data[ppm_pkg::CntW-1:0];
      end else if (cfg_index == ppm_pkg::RegWordNumber) begin
        phrase_word_number <= cfg_data[ppm_pkg::PartW-1:0];
      end
    end
  end

  assign eff_n = (parts_count > ppm_pkg::CntW'(ppm_pkg::MaxParts))
               ? ppm_pkg::CntW'(ppm_pkg::MaxParts) : parts_count;
  assign passthrough = (eff_n < ppm_pkg::CntW'(2));

  assign cur.doc_id      = doc_id;
  assign cur.section     = section;
  assign cur.position    = position;
  assign cur.part_number = part_number;

  assign accept = in_valid && in_ready;

  for (genvar k = 0; k < ppm_pkg::HistDepth; k++) begin : g_cell
    if (k == 0) begin : g_head
      ppm_cell u_cell (
        .clk            (clk),
        .rst            (rst),
        .shift          (accept),
        .offset         (ppm_pkg::OffW'(k + 1)),
        .cur            (cur),
        .cur_list_start (list_start),
        .prev_entry     (cur),
        .prev_valid     (1'b1),
        .entry          (entries[k]),
        .valid          (valids[k]),
        .match          (cell_hits[k])
      );
    end else begin : g_body
      ppm_cell u_cell (
        .clk            (clk),
        .rst            (rst),
        .shift          (accept),
        .offset         (ppm_pkg::OffW'(k + 1)),
        .cur            (cur),
        .cur_list_start (list_start),
        .prev_entry     (entries[k-1]),
        .prev_valid     (valids[k-1] && !list_start),
        .entry          (entries[k]),
        .valid          (valids[k]),
        .match          (cell_hits[k])
      );
    end
    assign needed[k] = (ppm_pkg::CntW'(k + 1) < eff_n);
  end

  assign hit  = passthrough || (&(cell_hits | ~needed));
  assign push = accept && hit;

  always_comb begin
    hit_data.doc_id  = doc_id;
    hit_data.section = section;
    if (passthrough) begin
      hit_data.position    = position;
      hit_data.word_number = part_number;
    end else begin
      hit_data.position    = position - ppm_pkg::PosW'(eff_n - ppm_pkg::CntW'(1));
      hit_data.word_number = phrase_word_number;
    end
  end

  ppm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (hit_data),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign hit_doc_id      = head.doc_id;
  assign hit_section     = head.section;
  assign hit_position    = head.position;
  assign hit_word_number = head.word_number;

  a_pass_emits : assert property (@(posedge clk) disable iff (rst)
    accept && passthrough |-> push)
    else $error("passthrough beat dropped");

  a_list_start_no_hit : assert property (@(posedge clk) disable iff (rst)
    accept && list_start && !passthrough |-> !push)
    else $error("hit on list start");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_full_has_out : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_window_clear : assert property (@(posedge clk) disable iff (rst)
    accept && list_start |=> valids[0] && !(|valids[ppm_pkg::HistDepth-1:1]))
    else $error("window not cleared on list start");

endmodule
